// File: hw/rtl/r2k_pkg.sv
// r2k_pkg: types, request codes and the romaji spelling table of the converter
// used by r2k_ctrl, r2k_datapath and romaji_to_kana_converter_core; no dependencies
package r2k_pkg;

    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_BS    = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    localparam int          FEED_DEPTH  = 3;
    localparam int          RES_DEPTH   = 6;
    localparam logic [15:0] SMALL_TSU   = 16'h3063;
    localparam logic [15:0] N_KANA      = 16'h3093;
    localparam logic [15:0] KANA_LO     = 16'h3041;
    localparam logic [15:0] KANA_HI     = 16'h3096;
    localparam logic [15:0] KATA_OFFSET = 16'h0060;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] key_char;
    } in_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic        char_valid;
        logic        removed;
        logic        last;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic q_empty;
        logic res_empty;
        logic out_free;
        logic emit_last;
    } sts_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] k0;
        logic [15:0] k1;
    } rk_hit_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_vowel(input logic [7:0] c);
        return (c == "a") || (c == "i") || (c == "u") || (c == "e") || (c == "o");
    endfunction

    function automatic logic [15:0] kana_shift(input logic [15:0] cp, input logic kata);
        if (kata && cp >= KANA_LO && cp <= KANA_HI)
        begin
            return cp + KATA_OFFSET;
        end
        return cp;
    endfunction

    // exact match of a spelling of the given length, first char in the top byte
    function automatic rk_hit_t rk_lookup(input logic [23:0] sp, input logic [1:0] len);
        rk_hit_t     r;
        logic [31:0] k;
        r.hit = 1'b1;
        k     = '0;
        unique case (len)
            2'd1:
            begin
                unique case (sp[23:16])
                    "a": k = 32'h3042_0000;
                    "i": k = 32'h3044_0000;
                    "u": k = 32'h3046_0000;
                    "e": k = 32'h3048_0000;
                    "o": k = 32'h304A_0000;
                    "-": k = 32'h30FC_0000;
                    ",": k = 32'h3001_0000;
                    ".": k = 32'h3002_0000;
                    "[": k = 32'h300C_0000;
                    "]": k = 32'h300D_0000;
                    "/": k = 32'h30FB_0000;
                    default: r.hit = 1'b0;
                endcase
            end
            2'd2:
            begin
                unique case (sp[23:8])
                    "ja": k = 32'h3058_3083;
                    "ji": k = 32'h3058_0000;
                    "ju": k = 32'h3058_3085;
                    "je": k = 32'h3058_3047;
                    "jo": k = 32'h3058_3087;
                    "fa": k = 32'h3075_3041;
                    "fi": k = 32'h3075_3043;
                    "fu": k = 32'h3075_0000;
                    "fe": k = 32'h3075_3047;
                    "fo": k = 32'h3075_3049;
                    "va": k = 32'h3094_3041;
                    "vi": k = 32'h3094_3043;
                    "vu": k = 32'h3094_0000;
                    "ve": k = 32'h3094_3047;
                    "vo": k = 32'h3094_3049;
                    "xa": k = 32'h3041_0000;
                    "xi": k = 32'h3043_0000;
                    "xu": k = 32'h3045_0000;
                    "xe": k = 32'h3047_0000;
                    "xo": k = 32'h3049_0000;
                    "ka": k = 32'h304B_0000;
                    "ki": k = 32'h304D_0000;
                    "ku": k = 32'h304F_0000;
                    "ke": k = 32'h3051_0000;
                    "ko": k = 32'h3053_0000;
                    "ga": k = 32'h304C_0000;
                    "gi": k = 32'h304E_0000;
                    "gu": k = 32'h3050_0000;
                    "ge": k = 32'h3052_0000;
                    "go": k = 32'h3054_0000;
                    "sa": k = 32'h3055_0000;
                    "si": k = 32'h3057_0000;
                    "su": k = 32'h3059_0000;
                    "se": k = 32'h305B_0000;
                    "so": k = 32'h305D_0000;
                    "za": k = 32'h3056_0000;
                    "zi": k = 32'h3058_0000;
                    "zu": k = 32'h305A_0000;
                    "ze": k = 32'h305C_0000;
                    "zo": k = 32'h305E_0000;
                    "ta": k = 32'h305F_0000;
                    "ti": k = 32'h3061_0000;
                    "tu": k = 32'h3064_0000;
                    "te": k = 32'h3066_0000;
                    "to": k = 32'h3068_0000;
                    "da": k = 32'h3060_0000;
                    "di": k = 32'h3062_0000;
                    "du": k = 32'h3065_0000;
                    "de": k = 32'h3067_0000;
                    "do": k = 32'h3069_0000;
                    "na": k = 32'h306A_0000;
                    "ni": k = 32'h306B_0000;
                    "nu": k = 32'h306C_0000;
                    "ne": k = 32'h306D_0000;
                    "no": k = 32'h306E_0000;
                    "ha": k = 32'h306F_0000;
                    "hi": k = 32'h3072_0000;
                    "hu": k = 32'h3075_0000;
                    "he": k = 32'h3078_0000;
                    "ho": k = 32'h307B_0000;
                    "ba": k = 32'h3070_0000;
                    "bi": k = 32'h3073_0000;
                    "bu": k = 32'h3076_0000;
                    "be": k = 32'h3079_0000;
                    "bo": k = 32'h307C_0000;
                    "pa": k = 32'h3071_0000;
                    "pi": k = 32'h3074_0000;
                    "pu": k = 32'h3077_0000;
                    "pe": k = 32'h307A_0000;
                    "po": k = 32'h307D_0000;
                    "ma": k = 32'h307E_0000;
                    "mi": k = 32'h307F_0000;
                    "mu": k = 32'h3080_0000;
                    "me": k = 32'h3081_0000;
                    "mo": k = 32'h3082_0000;
                    "ya": k = 32'h3084_0000;
                    "yi": k = 32'h3044_0000;
                    "yu": k = 32'h3086_0000;
                    "ye": k = 32'h3044_3047;
                    "yo": k = 32'h3088_0000;
                    "ra": k = 32'h3089_0000;
                    "ri": k = 32'h308A_0000;
                    "ru": k = 32'h308B_0000;
                    "re": k = 32'h308C_0000;
                    "ro": k = 32'h308D_0000;
                    "wa": k = 32'h308F_0000;
                    "wi": k = 32'h3046_3043;
                    "wu": k = 32'h3046_0000;
                    "we": k = 32'h3046_3047;
                    "wo": k = 32'h3092_0000;
                    "nn": k = 32'h3093_0000;
                    default: r.hit = 1'b0;
                endcase
            end
            2'd3:
            begin
                unique case (sp)
                    "kya": k = 32'h304D_3083;
                    "kyi": k = 32'h304D_3043;
                    "kyu": k = 32'h304D_3085;
                    "kye": k = 32'h304D_3047;
                    "kyo": k = 32'h304D_3087;
                    "gya": k = 32'h304E_3083;
                    "gyi": k = 32'h304E_3043;
                    "gyu": k = 32'h304E_3085;
                    "gye": k = 32'h304E_3047;
                    "gyo": k = 32'h304E_3087;
                    "sha": k = 32'h3057_3083;
                    "shi": k = 32'h3057_0000;
                    "shu": k = 32'h3057_3085;
                    "she": k = 32'h3057_3047;
                    "sho": k = 32'h3057_3087;
                    "sya": k = 32'h3057_3083;
                    "syu": k = 32'h3057_3085;
                    "syo": k = 32'h3057_3087;
                    "jya": k = 32'h3058_3083;
                    "jyu": k = 32'h3058_3085;
                    "jyo": k = 32'h3058_3087;
                    "cha": k = 32'h3061_3083;
                    "chi": k = 32'h3061_0000;
                    "chu": k = 32'h3061_3085;
                    "che": k = 32'h3061_3047;
                    "cho": k = 32'h3061_3087;
                    "tya": k = 32'h3061_3083;
                    "tyu": k = 32'h3061_3085;
                    "tyo": k = 32'h3061_3087;
                    "tsu": k = 32'h3064_0000;
                    "tsa": k = 32'h3064_3041;
                    "tsi": k = 32'h3064_3043;
                    "tse": k = 32'h3064_3047;
                    "tso": k = 32'h3064_3049;
                    "nya": k = 32'h306B_3083;
                    "nyu": k = 32'h306B_3085;
                    "nyo": k = 32'h306B_3087;
                    "hya": k = 32'h3072_3083;
                    "hyu": k = 32'h3072_3085;
                    "hyo": k = 32'h3072_3087;
                    "bya": k = 32'h3073_3083;
                    "byu": k = 32'h3073_3085;
                    "byo": k = 32'h3073_3087;
                    "pya": k = 32'h3074_3083;
                    "pyu": k = 32'h3074_3085;
                    "pyo": k = 32'h3074_3087;
                    "mya": k = 32'h307F_3083;
                    "myu": k = 32'h307F_3085;
                    "myo": k = 32'h307F_3087;
                    "rya": k = 32'h308A_3083;
                    "ryu": k = 32'h308A_3085;
                    "ryo": k = 32'h308A_3087;
                    "dha": k = 32'h3067_3083;
                    "dhi": k = 32'h3067_3043;
                    "dhu": k = 32'h3067_3085;
                    "dho": k = 32'h3067_3087;
                    "tha": k = 32'h3066_3083;
                    "thi": k = 32'h3066_3043;
                    "thu": k = 32'h3066_3085;
                    "tho": k = 32'h3066_3087;
                    "wha": k = 32'h3046_3041;
                    "whi": k = 32'h3046_3043;
                    "whe": k = 32'h3046_3047;
                    "who": k = 32'h3046_3049;
                    "xtu": k = 32'h3063_0000;
                    "ltu": k = 32'h3063_0000;
                    "xya": k = 32'h3083_0000;
                    "xyu": k = 32'h3085_0000;
                    "xyo": k = 32'h3087_0000;
                    default: r.hit = 1'b0;
                endcase
            end
            default: r.hit = 1'b0;
        endcase
        r.k0 = k[31:16];
        r.k1 = k[15:0];
        return r;
    endfunction

    // true when a longer spelling starts with the first len chars
    function automatic logic rk_grow(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [1:0] len);
        logic g;
        g = 1'b0;
        unique case (len)
            2'd1:
            begin
                unique case (c0)
                    "k", "g", "s", "j", "c", "t", "n", "h", "b", "p",
                    "m", "r", "f", "v", "d", "w", "x", "l", "y", "z": g = 1'b1;
                    default: g = 1'b0;
                endcase
            end
            2'd2:
            begin
                unique case ({c0, c1})
                    "ky", "gy", "sh", "sy", "jy", "ch", "ty", "ts", "ny", "hy",
                    "by", "py", "my", "ry", "dh", "th", "wh", "xt", "lt", "xy": g = 1'b1;
                    default: g = 1'b0;
                endcase
            end
            default: g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

// File: hw/rtl/r2k_ctrl.sv
// r2k_ctrl: sequencer for the converter: accept, feed steps and result streaming
// depends on r2k_pkg
module r2k_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           req_type,
    output logic                 in_stall,
    input  r2k_pkg::sts_t        sts,
    output r2k_pkg::cmd_t        cmd
);

    r2k_pkg::state_t state_reg;
    r2k_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= r2k_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            r2k_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (req_type == r2k_pkg::REQ_KEY)
                    begin
                        state_next = r2k_pkg::ST_FEED;
                    end
                    else if (req_type == r2k_pkg::REQ_BS || req_type == r2k_pkg::REQ_FLUSH)
                    begin
                        state_next = r2k_pkg::ST_EMIT;
                    end
                end
            end
            r2k_pkg::ST_FEED:
            begin
                if (sts.q_empty)
                begin
                    state_next = r2k_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            r2k_pkg::ST_EMIT:
            begin
                if (sts.res_empty)
                begin
                    state_next = r2k_pkg::ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = r2k_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = r2k_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/r2k_datapath.sv
// r2k_datapath: pending buffer, feed queue, table match, result buffer and output register
// depends on r2k_pkg
module r2k_datapath #(
    parameter int PENDING_DEPTH = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  r2k_pkg::in_t         in_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output r2k_pkg::out_t        out_data,
    input  r2k_pkg::cmd_t        cmd,
    output r2k_pkg::sts_t        sts
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);

    logic              kata_reg;
    logic [7:0]        pend_reg [PENDING_DEPTH];
    logic [7:0]        pend0_next;
    logic [7:0]        pend1_next;
    logic [CW-1:0]     pcnt_reg;
    logic [CW-1:0]     pcnt_next;
    logic [7:0]        q_reg [r2k_pkg::FEED_DEPTH];
    logic [7:0]        q_next [r2k_pkg::FEED_DEPTH];
    logic [1:0]        qcnt_reg;
    logic [1:0]        qcnt_next;
    logic [15:0]       res_reg [r2k_pkg::RES_DEPTH];
    logic [2:0]        rcnt_reg;
    logic [2:0]        rcnt_next;
    logic [2:0]        e_reg;
    logic              bs_reg;
    logic              bs_next;
    logic              rem_reg;
    logic              rem_next;
    logic              out_valid_reg;
    r2k_pkg::out_t     out_reg;

    logic [7:0]        h;
    logic [7:0]        p0;
    logic [7:0]        p1;
    logic [7:0]        p_last;
    logic [7:0]        bb [3];
    logic [1:0]        n;
    r2k_pkg::rk_hit_t  ex1;
    r2k_pkg::rk_hit_t  ex2;
    r2k_pkg::rk_hit_t  ex3;
    r2k_pkg::rk_hit_t  exn;
    logic              gr;
    logic [1:0]        push_n;
    logic [15:0]       push_a;
    logic [15:0]       push_b;
    logic [2:0]        base;
    logic [3:0]        wr_b;

    assign p0     = pend_reg[0];
    assign p1     = pend_reg[1];
    assign h      = r2k_pkg::fold_case(q_reg[0]);
    assign p_last = (pcnt_reg == CW'(2)) ? p1 : p0;
    assign n      = 2'(pcnt_reg) + 2'd1;

    // candidate buffer: pending chars followed by the head char
    always_comb
    begin
        bb[0] = (pcnt_reg != '0) ? p0 : h;
        bb[1] = (pcnt_reg == CW'(2)) ? p1 : ((pcnt_reg == CW'(1)) ? h : 8'h00);
        bb[2] = (pcnt_reg == CW'(2)) ? h : 8'h00;
    end

    assign ex1 = r2k_pkg::rk_lookup({bb[0], 16'h0000}, 2'd1);
    assign ex2 = r2k_pkg::rk_lookup({bb[0], bb[1], 8'h00}, 2'd2);
    assign ex3 = r2k_pkg::rk_lookup({bb[0], bb[1], bb[2]}, 2'd3);
    assign exn = (n == 2'd3) ? ex3 : ((n == 2'd2) ? ex2 : ex1);
    assign gr  = r2k_pkg::rk_grow(bb[0], bb[1], n);

    always_comb
    begin
        logic [1:0]       s;
        logic [1:0]       r;
        logic [7:0]       rf [2];
        r2k_pkg::rk_hit_t pe;
        logic             pfound;
        int               k;

        pend0_next = p0;
        pend1_next = p1;
        pcnt_next  = pcnt_reg;
        qcnt_next  = qcnt_reg;
        for (int i = 0; i < r2k_pkg::FEED_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        bs_next  = bs_reg;
        rem_next = rem_reg;
        push_n   = 2'd0;
        push_a   = 16'h0000;
        push_b   = 16'h0000;
        s        = 2'd1;
        r        = 2'd0;
        pe       = ex1;
        pfound   = 1'b0;
        rf[0]    = 8'h00;
        rf[1]    = 8'h00;
        k        = 0;

        if (cmd.accept)
        begin
            case (in_data.req_type)
                r2k_pkg::REQ_KEY:
                begin
                    bs_next   = 1'b0;
                    q_next[0] = in_data.key_char;
                    qcnt_next = 2'd1;
                end
                r2k_pkg::REQ_BS:
                begin
                    bs_next  = 1'b1;
                    rem_next = (pcnt_reg != '0);
                    if (pcnt_reg != '0)
                    begin
                        pcnt_next = pcnt_reg - CW'(1);
                    end
                    push_n = 2'd1;
                end
                r2k_pkg::REQ_FLUSH:
                begin
                    bs_next = 1'b0;
                    if (pcnt_reg == CW'(1) && p0 == "n")
                    begin
                        push_n = 2'd1;
                        push_a = r2k_pkg::N_KANA;
                    end
                    else
                    begin
                        push_n = 2'(pcnt_reg);
                        push_a = {8'h00, p0};
                        push_b = {8'h00, p1};
                    end
                    pcnt_next = '0;
                end
                default: bs_next = bs_reg;
            endcase
        end
        else if (cmd.step)
        begin
            if (pcnt_reg != '0 && p_last == h && !r2k_pkg::is_vowel(h) && h != "n")
            begin
                // doubled consonant
                push_n     = 2'd1;
                push_a     = r2k_pkg::SMALL_TSU;
                pend0_next = h;
                pcnt_next  = CW'(1);
                r          = 2'd0;
                for (int i = 0; i < r2k_pkg::FEED_DEPTH; i++)
                begin
                    k = i + 1;
                    if (k < r2k_pkg::FEED_DEPTH)
                    begin
                        q_next[i] = q_reg[k];
                    end
                end
                qcnt_next = qcnt_reg - 2'd1;
            end
            else if (pcnt_reg == CW'(1) && p0 == "n" && !r2k_pkg::is_vowel(h) &&
                     h != "n" && h != "y")
            begin
                // n before a consonant, head char is fed again
                push_n    = 2'd1;
                push_a    = r2k_pkg::N_KANA;
                pcnt_next = '0;
            end
            else
            begin
                if (exn.hit || gr)
                begin
                    if (exn.hit && !gr)
                    begin
                        push_n    = exn.k1 != 16'h0000 ? 2'd2 : 2'd1;
                        push_a    = exn.k0;
                        push_b    = exn.k1;
                        pcnt_next = '0;
                    end
                    else
                    begin
                        pend0_next = bb[0];
                        pend1_next = bb[1];
                        pcnt_next  = CW'(n);
                    end
                    r = 2'd0;
                end
                else
                begin
                    pcnt_next = '0;
                    if (n == 2'd3 && ex2.hit)
                    begin
                        pe     = ex2;
                        pfound = 1'b1;
                        s      = 2'd2;
                    end
                    else if (n != 2'd1 && ex1.hit)
                    begin
                        pe     = ex1;
                        pfound = 1'b1;
                        s      = 2'd1;
                    end
                    if (pfound)
                    begin
                        push_n = pe.k1 != 16'h0000 ? 2'd2 : 2'd1;
                        push_a = pe.k0;
                        push_b = pe.k1;
                    end
                    else
                    begin
                        push_n = 2'd1;
                        push_a = {8'h00, bb[0]};
                        s      = 2'd1;
                    end
                    r     = n - s;
                    rf[0] = bb[s];
                    rf[1] = bb[2];
                end
                // leftover chars go ahead of the rest of the queue
                for (int i = 0; i < r2k_pkg::FEED_DEPTH; i++)
                begin
                    if (i < int'(r))
                    begin
                        q_next[i] = rf[i[0]];
                    end
                    else
                    begin
                        k = i - int'(r) + 1;
                        if (k < r2k_pkg::FEED_DEPTH)
                        begin
                            q_next[i] = q_reg[k];
                        end
                    end
                end
                qcnt_next = qcnt_reg - 2'd1 + r;
            end
        end
    end

    assign base = cmd.accept ? 3'd0 : rcnt_reg;
    assign wr_b = {1'b0, base} + 4'd1;

    always_comb
    begin
        logic [3:0] sum;
        sum = {1'b0, base} + {2'b00, push_n};
        if (sum > 4'(r2k_pkg::RES_DEPTH))
        begin
            rcnt_next = 3'(r2k_pkg::RES_DEPTH);
        end
        else
        begin
            rcnt_next = sum[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kata_reg      <= 1'b0;
            pcnt_reg      <= '0;
            qcnt_reg      <= 2'd0;
            rcnt_reg      <= 3'd0;
            e_reg         <= 3'd0;
            bs_reg        <= 1'b0;
            rem_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                kata_reg <= cfg_wr_data;
            end
            pcnt_reg <= pcnt_next;
            qcnt_reg <= qcnt_next;
            bs_reg   <= bs_next;
            rem_reg  <= rem_next;
            if (cmd.accept || cmd.step)
            begin
                rcnt_reg <= rcnt_next;
            end
            if (cmd.accept)
            begin
                e_reg <= 3'd0;
            end
            else if (cmd.load_out)
            begin
                e_reg <= e_reg + 3'd1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend0_next;
        pend_reg[1] <= pend1_next;
        for (int i = 0; i < r2k_pkg::FEED_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
        if (push_n != 2'd0 && base < 3'(r2k_pkg::RES_DEPTH))
        begin
            res_reg[base] <= r2k_pkg::kana_shift(push_a, kata_reg);
        end
        if (push_n == 2'd2 && wr_b < 4'(r2k_pkg::RES_DEPTH))
        begin
            res_reg[wr_b[2:0]] <= r2k_pkg::kana_shift(push_b, kata_reg);
        end
        if (cmd.load_out)
        begin
            out_reg.code_point <= res_reg[e_reg];
            out_reg.char_valid <= !bs_reg;
            out_reg.removed    <= bs_reg && rem_reg;
            out_reg.last       <= sts.emit_last;
        end
    end

    // deeper pending storage is only kept for layout of the buffer
    for (genvar g = 2; g < PENDING_DEPTH; g++)
    begin : g_spare
        always_ff @(posedge clk)
        begin
            pend_reg[g] <= 8'h00;
        end
    end

    assign sts.q_empty   = (qcnt_reg == 2'd0);
    assign sts.res_empty = (rcnt_reg == 3'd0);
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.emit_last = (e_reg == rcnt_reg - 3'd1);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/romaji_to_kana_converter_core.sv
// Keyboard events go in; romaji is matched against a fixed spelling table and
// kana code points come out one beat at a time. An accepted key enters, then the
// feed state steps one character at a time through the matcher (one to four
// characters, since unmatched characters are fed again), then leaves the feed loop,
// and the result beats follow, one per cycle when the output is not stalled.
// Backspace and flush skip the feed loop. The feed sequencer takes one character per
// cycle and results leave through a single output register. katakana_mode is to be
// written through cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce this.
module romaji_to_kana_converter_core #(
    parameter int PENDING_DEPTH = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  r2k_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output r2k_pkg::out_t    out_data
);

    r2k_pkg::cmd_t cmd;
    r2k_pkg::sts_t sts;

    r2k_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    r2k_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef SYNTHESIS
    a_step_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !sts.q_empty)
        else $error("feed step with empty queue");

    a_key_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.req_type == r2k_pkg::REQ_KEY) |=> in_stall)
        else $error("input not held off while a key is processed");

    a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && (cmd.load_out || cmd.step)))
        else $error("accept overlaps feed or emit");
`endif

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for romaji_to_kana_converter_core, with its own
// spelling table, pending-buffer predictor, queue-fed driver and checking monitor
// depends on r2k_pkg and romaji_to_kana_converter_core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import r2k_pkg::*;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_DRAIN,
        ACT_CFG
    } act_kind_t;

    typedef struct {
        act_kind_t kind;
        in_t       data;
        logic      mode;
    } action_t;

    typedef struct {
        byte unsigned c[3];
        int           len;
        logic [15:0]  k0;
        logic [15:0]  k1;
    } spelling_t;

    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 400;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_wr_en = 1'b0;
    logic  cfg_wr_data = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    in_t   in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    out_t  out_data;

    spelling_t   spellings[$];
    action_t     actions[$];
    out_t        kana_expected[$];
    logic [15:0] emitted[$];

    // predictor state
    logic         kata_mode = 1'b0;
    byte unsigned pend[3];
    int           pend_cnt = 0;

    int  sent_items = 0;
    int  beats_seen = 0;
    int  errors = 0;
    int  settle = 0;
    int  hold = 0;
    bit  hold_done = 0;
    bit  quiet = 0;
    bit  any_accept;
    int  idle_cycles = 0;

    romaji_to_kana_converter_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void sp(string s, logic [15:0] a, logic [15:0] b);
        spelling_t e;
        e.len = s.len();
        for (int i = 0; i < 3; i++)
        begin
            e.c[i] = (i < e.len) ? s[i] : 8'h00;
        end
        e.k0 = a;
        e.k1 = b;
        spellings.push_back(e);
    endfunction

    function automatic bit head_match(int idx, byte unsigned b[4], int n);
        for (int i = 0; i < n; i++)
        begin
            if (spellings[idx].c[i] != b[i])
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic int find_exact(byte unsigned b[4], int n);
        for (int i = 0; i < spellings.size(); i++)
        begin
            if (spellings[i].len == n && head_match(i, b, n))
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit can_extend(byte unsigned b[4], int n);
        for (int i = 0; i < spellings.size(); i++)
        begin
            if (spellings[i].len > n && head_match(i, b, n))
            begin
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void put_cp(logic [15:0] cp);
        if (emitted.size() < RES_DEPTH)
        begin
            emitted.push_back(cp);
        end
    endfunction

    function automatic void put_kana(logic [15:0] cp);
        if (kata_mode && cp >= 16'h3041 && cp <= 16'h3096)
        begin
            cp = cp + 16'h0060;
        end
        put_cp(cp);
    endfunction

    function automatic void put_spelling(int idx);
        put_kana(spellings[idx].k0);
        if (spellings[idx].k1 != 0)
        begin
            put_kana(spellings[idx].k1);
        end
    endfunction

    function automatic bit vowel(byte unsigned c);
        return c == "a" || c == "i" || c == "u" || c == "e" || c == "o";
    endfunction

    function automatic void feed_char(byte unsigned c);
        byte unsigned lc;
        byte unsigned b[4];
        int           n;
        int           idx;
        bit           g;
        lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
        if (pend_cnt > 0 && pend[pend_cnt-1] == lc && !vowel(lc) && lc != "n")
        begin
            put_kana(SMALL_TSU);
            pend[0] = lc;
            pend_cnt = 1;
            return;
        end
        if (pend_cnt == 1 && pend[0] == "n" && !vowel(lc) && lc != "n" && lc != "y")
        begin
            put_kana(N_KANA);
            pend_cnt = 0;
            feed_char(lc);
            return;
        end
        n = (pend_cnt < 3) ? pend_cnt : 2;
        for (int i = 0; i < n; i++)
        begin
            b[i] = pend[i];
        end
        b[n] = lc;
        n++;
        idx = find_exact(b, n);
        g = can_extend(b, n);
        if (idx >= 0 || g)
        begin
            if (idx >= 0 && !g)
            begin
                put_spelling(idx);
                pend_cnt = 0;
            end
            else
            begin
                for (int i = 0; i < n && i < 3; i++)
                begin
                    pend[i] = b[i];
                end
                pend_cnt = (n < 3) ? n : 3;
            end
            return;
        end
        pend_cnt = 0;
        for (int l = n; l >= 1; l--)
        begin
            idx = find_exact(b, l);
            if (idx >= 0)
            begin
                put_spelling(idx);
                for (int i = l; i < n; i++)
                begin
                    feed_char(b[i]);
                end
                return;
            end
        end
        put_cp(b[0]);
        for (int i = 1; i < n; i++)
        begin
            feed_char(b[i]);
        end
    endfunction

    function automatic void predict_kana(in_t d);
        out_t r;
        emitted.delete();
        case (d.req_type)
            REQ_BS:
            begin
                r = '0;
                r.removed = (pend_cnt > 0);
                r.last = 1'b1;
                if (pend_cnt > 0)
                begin
                    pend_cnt--;
                end
                kana_expected.push_back(r);
                return;
            end
            REQ_KEY: feed_char(d.key_char);
            REQ_FLUSH:
            begin
                if (pend_cnt == 1 && pend[0] == "n")
                begin
                    put_kana(N_KANA);
                end
                else
                begin
                    for (int i = 0; i < pend_cnt; i++)
                    begin
                        put_cp({8'h00, pend[i]});
                    end
                end
                pend_cnt = 0;
            end
            default: return;
        endcase
        foreach (emitted[k])
        begin
            r.code_point = emitted[k];
            r.char_valid = 1'b1;
            r.removed = 1'b0;
            r.last = (k == emitted.size() - 1);
            kana_expected.push_back(r);
        end
    endfunction

    function automatic void add_item(logic [1:0] rt, logic [7:0] kc);
        action_t a;
        a.kind = ACT_ITEM;
        a.data.req_type = rt;
        a.data.key_char = kc;
        a.mode = 1'b0;
        actions.push_back(a);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_item(REQ_KEY, s[i]);
        end
    endfunction

    function automatic void add_mode(logic m);
        action_t a;
        a.kind = ACT_DRAIN;
        a.data = '0;
        a.mode = m;
        actions.push_back(a);
        a.kind = ACT_CFG;
        actions.push_back(a);
    endfunction

    function automatic void add_random(int count);
        int        made;
        int        pick;
        spelling_t e;
        byte unsigned ch;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                e = spellings[$urandom_range(0, spellings.size() - 1)];
                if ($urandom_range(0, 5) == 0)
                begin
                    add_item(REQ_KEY, e.c[0]);
                    made++;
                end
                for (int i = 0; i < e.len; i++)
                begin
                    ch = e.c[i];
                    if (ch >= "a" && ch <= "z" && $urandom_range(0, 3) == 0)
                    begin
                        ch = ch - 8'h20;
                    end
                    add_item(REQ_KEY, ch);
                    made++;
                end
            end
            else if (pick < 80)
            begin
                add_item(REQ_KEY, $urandom_range(0, 255));
                made++;
            end
            else if (pick < 88)
            begin
                add_item(REQ_BS, $urandom_range(0, 255));
                made++;
            end
            else if (pick < 96)
            begin
                add_item(REQ_FLUSH, $urandom_range(0, 255));
                made++;
            end
            else
            begin
                add_item(2'd3, $urandom_range(0, 255));
            end
        end
    endfunction

    function automatic void build_spellings();
        sp("kya",16'h304D,16'h3083); sp("kyi",16'h304D,16'h3043); sp("kyu",16'h304D,16'h3085);
        sp("kye",16'h304D,16'h3047); sp("kyo",16'h304D,16'h3087);
        sp("gya",16'h304E,16'h3083); sp("gyi",16'h304E,16'h3043); sp("gyu",16'h304E,16'h3085);
        sp("gye",16'h304E,16'h3047); sp("gyo",16'h304E,16'h3087);
        sp("sha",16'h3057,16'h3083); sp("shi",16'h3057,0); sp("shu",16'h3057,16'h3085);
        sp("she",16'h3057,16'h3047); sp("sho",16'h3057,16'h3087);
        sp("sya",16'h3057,16'h3083); sp("syu",16'h3057,16'h3085); sp("syo",16'h3057,16'h3087);
        sp("ja",16'h3058,16'h3083); sp("ji",16'h3058,0); sp("ju",16'h3058,16'h3085);
        sp("je",16'h3058,16'h3047); sp("jo",16'h3058,16'h3087);
        sp("jya",16'h3058,16'h3083); sp("jyu",16'h3058,16'h3085); sp("jyo",16'h3058,16'h3087);
        sp("cha",16'h3061,16'h3083); sp("chi",16'h3061,0); sp("chu",16'h3061,16'h3085);
        sp("che",16'h3061,16'h3047); sp("cho",16'h3061,16'h3087);
        sp("tya",16'h3061,16'h3083); sp("tyu",16'h3061,16'h3085); sp("tyo",16'h3061,16'h3087);
        sp("tsu",16'h3064,0); sp("tsa",16'h3064,16'h3041); sp("tsi",16'h3064,16'h3043);
        sp("tse",16'h3064,16'h3047); sp("tso",16'h3064,16'h3049);
        sp("nya",16'h306B,16'h3083); sp("nyu",16'h306B,16'h3085); sp("nyo",16'h306B,16'h3087);
        sp("hya",16'h3072,16'h3083); sp("hyu",16'h3072,16'h3085); sp("hyo",16'h3072,16'h3087);
        sp("bya",16'h3073,16'h3083); sp("byu",16'h3073,16'h3085); sp("byo",16'h3073,16'h3087);
        sp("pya",16'h3074,16'h3083); sp("pyu",16'h3074,16'h3085); sp("pyo",16'h3074,16'h3087);
        sp("mya",16'h307F,16'h3083); sp("myu",16'h307F,16'h3085); sp("myo",16'h307F,16'h3087);
        sp("rya",16'h308A,16'h3083); sp("ryu",16'h308A,16'h3085); sp("ryo",16'h308A,16'h3087);
        sp("fa",16'h3075,16'h3041); sp("fi",16'h3075,16'h3043); sp("fu",16'h3075,0);
        sp("fe",16'h3075,16'h3047); sp("fo",16'h3075,16'h3049);
        sp("va",16'h3094,16'h3041); sp("vi",16'h3094,16'h3043); sp("vu",16'h3094,0);
        sp("ve",16'h3094,16'h3047); sp("vo",16'h3094,16'h3049);
        sp("dha",16'h3067,16'h3083); sp("dhi",16'h3067,16'h3043); sp("dhu",16'h3067,16'h3085);
        sp("dho",16'h3067,16'h3087);
        sp("tha",16'h3066,16'h3083); sp("thi",16'h3066,16'h3043); sp("thu",16'h3066,16'h3085);
        sp("tho",16'h3066,16'h3087);
        sp("wha",16'h3046,16'h3041); sp("whi",16'h3046,16'h3043); sp("whe",16'h3046,16'h3047);
        sp("who",16'h3046,16'h3049);
        sp("xtu",16'h3063,0); sp("ltu",16'h3063,0); sp("xya",16'h3083,0);
        sp("xyu",16'h3085,0); sp("xyo",16'h3087,0);
        sp("xa",16'h3041,0); sp("xi",16'h3043,0); sp("xu",16'h3045,0);
        sp("xe",16'h3047,0); sp("xo",16'h3049,0);
        sp("ka",16'h304B,0); sp("ki",16'h304D,0); sp("ku",16'h304F,0);
        sp("ke",16'h3051,0); sp("ko",16'h3053,0);
        sp("ga",16'h304C,0); sp("gi",16'h304E,0); sp("gu",16'h3050,0);
        sp("ge",16'h3052,0); sp("go",16'h3054,0);
        sp("sa",16'h3055,0); sp("si",16'h3057,0); sp("su",16'h3059,0);
        sp("se",16'h305B,0); sp("so",16'h305D,0);
        sp("za",16'h3056,0); sp("zi",16'h3058,0); sp("zu",16'h305A,0);
        sp("ze",16'h305C,0); sp("zo",16'h305E,0);
        sp("ta",16'h305F,0); sp("ti",16'h3061,0); sp("tu",16'h3064,0);
        sp("te",16'h3066,0); sp("to",16'h3068,0);
        sp("da",16'h3060,0); sp("di",16'h3062,0); sp("du",16'h3065,0);
        sp("de",16'h3067,0); sp("do",16'h3069,0);
        sp("na",16'h306A,0); sp("ni",16'h306B,0); sp("nu",16'h306C,0);
        sp("ne",16'h306D,0); sp("no",16'h306E,0);
        sp("ha",16'h306F,0); sp("hi",16'h3072,0); sp("hu",16'h3075,0);
        sp("he",16'h3078,0); sp("ho",16'h307B,0);
        sp("ba",16'h3070,0); sp("bi",16'h3073,0); sp("bu",16'h3076,0);
        sp("be",16'h3079,0); sp("bo",16'h307C,0);
        sp("pa",16'h3071,0); sp("pi",16'h3074,0); sp("pu",16'h3077,0);
        sp("pe",16'h307A,0); sp("po",16'h307D,0);
        sp("ma",16'h307E,0); sp("mi",16'h307F,0); sp("mu",16'h3080,0);
        sp("me",16'h3081,0); sp("mo",16'h3082,0);
        sp("ya",16'h3084,0); sp("yi",16'h3044,0); sp("yu",16'h3086,0);
        sp("ye",16'h3044,16'h3047); sp("yo",16'h3088,0);
        sp("ra",16'h3089,0); sp("ri",16'h308A,0); sp("ru",16'h308B,0);
        sp("re",16'h308C,0); sp("ro",16'h308D,0);
        sp("wa",16'h308F,0); sp("wi",16'h3046,16'h3043); sp("wu",16'h3046,0);
        sp("we",16'h3046,16'h3047); sp("wo",16'h3092,0);
        sp("nn",16'h3093,0);
        sp("a",16'h3042,0); sp("i",16'h3044,0); sp("u",16'h3046,0);
        sp("e",16'h3048,0); sp("o",16'h304A,0);
        sp("-",16'h30FC,0); sp(",",16'h3001,0); sp(".",16'h3002,0);
        sp("[",16'h300C,0); sp("]",16'h300D,0); sp("/",16'h30FB,0);
    endfunction

    // stimulus plan and end of run
    initial
    begin
        build_spellings();
        // directed: folding, small tsu, n-kana, fallbacks, raw bytes, backspace, flush
        add_text("KyA");
        add_text("kka");
        add_text("nk");
        add_item(REQ_BS, 8'hFF);
        add_item(REQ_BS, 8'h00);
        add_text("n");
        add_item(REQ_FLUSH, 8'h00);
        add_item(REQ_FLUSH, 8'hFF);
        add_text("kyq");
        add_item(REQ_KEY, 8'h00);
        add_item(REQ_KEY, 8'hFF);
        add_text("-/");
        add_text("sh");
        add_item(2'd3, 8'h61);
        add_item(REQ_FLUSH, 8'h00);
        add_mode(1'b1);
        add_text("ye-tsa");
        add_random(RANDOM_ITEMS / 3);
        // sender waits for every result before going on
        add_mode(1'b1);
        add_random(RANDOM_ITEMS / 3);
        add_mode(1'b0);
        add_random(RANDOM_ITEMS / 3);
        add_item(REQ_FLUSH, 8'h00);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (actions.size() == 0 && !in_valid && kana_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && kana_expected.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic    nxt_valid;
        action_t a;
        bit      took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                predict_kana(in_data);
            end
            nxt_valid = in_valid && !took;
            cfg_wr_en <= 1'b0;
            if (!nxt_valid && actions.size() > 0)
            begin
                a = actions[0];
                if (settle > 0)
                begin
                    settle--;
                end
                else if (a.kind == ACT_DRAIN)
                begin
                    if (!took && !in_valid && kana_expected.size() == 0)
                    begin
                        // keys without results may still be in the pipe
                        settle = SETTLE_CYCLES;
                        void'(actions.pop_front());
                    end
                end
                else if (a.kind == ACT_CFG)
                begin
                    cfg_wr_en <= 1'b1;
                    cfg_wr_data <= a.mode;
                    kata_mode = a.mode;
                    void'(actions.pop_front());
                end
                else if (quiet || $urandom_range(0, 99) >= 26)
                begin
                    nxt_valid = 1'b1;
                    in_data <= a.data;
                    void'(actions.pop_front());
                    sent_items++;
                    quiet = (sent_items >= 180 && sent_items < 260);
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (kana_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected beat %h", out_data);
                    end
                end
                else
                begin
                    want = kana_expected.pop_front();
                    if (want !== out_data)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: exp cp=%h cv=%b rm=%b last=%b got cp=%h cv=%b rm=%b last=%b",
                                     want.code_point, want.char_valid, want.removed, want.last,
                                     out_data.code_point, out_data.char_valid,
                                     out_data.removed, out_data.last);
                        end
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && beats_seen >= 60)
            begin
                hold_done = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 26);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        any_accept = (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en;
        if (any_accept || hold > 0 || settle > 0)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
